FILE: sv/wrapped_text_glyph_renderer_unit_assert.svh
// Assertion macros shared by the checker of the glyph renderer.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef WRAPPED_TEXT_GLYPH_RENDERER_UNIT_ASSERT_SVH
`define WRAPPED_TEXT_GLYPH_RENDERER_UNIT_ASSERT_SVH

// same-cycle implication
`define WTGR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wtgr: same-cycle check failed");

// next-cycle implication
`define WTGR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wtgr: next-cycle check failed");

`endif

FILE: sv/wtgr_pkg.sv
// Package of the glyph renderer: config struct, queue entry, font tables and
// glyph row lookup. Depends on nothing.
package wtgr_pkg;

  localparam int DEF_MAX_SCALE   = 4;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_COLS = 5;
  localparam int CHAR_PITCH = 6;
  localparam int LINE_PITCH = 9;
  localparam int MASK_W     = 20;

  // sized for the widest scale the parameter allows (8)
  localparam int SCALE_W = 4;
  localparam int X_W     = 13;
  localparam int Y_W     = 12;

  localparam logic [9:0]  COORD_MAX = 10'd1023;
  localparam logic [10:0] FRAME_MAX = 11'd1024;
  localparam logic [4:0]  DOT_ROW   = 5'h04;
  localparam logic [4:0]  FULL_ROW  = 5'h1F;

  localparam logic [7:0] CH_NEWLINE    = 8'd10;
  localparam logic [7:0] CH_SPACE      = 8'd32;
  localparam logic [7:0] CH_DASH       = 8'd45;
  localparam logic [7:0] CH_DOT        = 8'd46;
  localparam logic [7:0] CH_SLASH      = 8'd47;
  localparam logic [7:0] CH_ZERO       = 8'd48;
  localparam logic [7:0] CH_NINE       = 8'd57;
  localparam logic [7:0] CH_COLON      = 8'd58;
  localparam logic [7:0] CH_LESS       = 8'd60;
  localparam logic [7:0] CH_GREATER    = 8'd62;
  localparam logic [7:0] CH_UPPER_A    = 8'd65;
  localparam logic [7:0] CH_UPPER_Z    = 8'd90;
  localparam logic [7:0] CH_BACKSLASH  = 8'd92;
  localparam logic [7:0] CH_UNDERSCORE = 8'd95;
  localparam logic [7:0] CH_LOWER_A    = 8'd97;
  localparam logic [7:0] CH_LOWER_Z    = 8'd122;
  localparam logic [7:0] CASE_FOLD     = 8'd32;

  typedef enum logic [2:0] {
    REG_ORIGIN_X        = 3'd0,
    REG_ORIGIN_Y        = 3'd1,
    REG_GLYPH_SCALE     = 3'd2,
    REG_LINE_CHAR_LIMIT = 3'd3,
    REG_LINE_LIMIT      = 3'd4,
    REG_FRAME_WIDTH     = 3'd5,
    REG_FRAME_HEIGHT    = 3'd6,
    REG_TEXT_COLOR      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [9:0]  origin_x;
    logic [9:0]  origin_y;
    logic [2:0]  glyph_scale;
    logic [6:0]  line_char_limit;
    logic [3:0]  line_limit;
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    logic [15:0] text_color;
  } cfg_t;

  // one drawn character, handed from front to back
  typedef struct packed {
    logic [7:0]         code;
    logic [9:0]         run_start_x;
    logic [MASK_W-1:0]  col_mask;
    logic [Y_W-1:0]     ybase;
    logic [SCALE_W-1:0] scale;
  } entry_t;

  localparam logic [4:0] FONT_DIGITS [10][7] = '{
    '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
    '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
    '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
    '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
    '{5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E}
  };

  localparam logic [4:0] FONT_LETTERS [26][7] = '{
    '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
    '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
    '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
    '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E},
    '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
    '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    '{5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C},
    '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
    '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
    '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
    '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
    '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
    '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A},
    '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
    '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F}
  };

  // 5-bit pattern of glyph row r (0..6) of an upper-case code; bit 4 is leftmost
  function automatic logic [4:0] glyph_row(input logic [7:0] c, input logic [2:0] r);
    logic [4:0] g;
    g = DOT_ROW;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      g = FONT_LETTERS[5'(c - CH_UPPER_A)][r];
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      g = FONT_DIGITS[4'(c - CH_ZERO)][r];
    end else begin
      case (c)
        CH_COLON:      g = (r == 3'd1 || r == 3'd5) ? DOT_ROW : 5'h00;
        CH_DOT:        g = (r == 3'd6) ? DOT_ROW : 5'h00;
        CH_DASH:       g = (r == 3'd3) ? FULL_ROW : 5'h00;
        CH_UNDERSCORE: g = (r == 3'd6) ? FULL_ROW : 5'h00;
        CH_SLASH:      g = 5'd1 << ((r < 3'd5) ? r : 3'd4);
        CH_BACKSLASH:  g = 5'd1 << ((r < 3'd5) ? 3'(3'd4 - r) : 3'd0);
        CH_LESS:       g = (r < 3'd4) ? (5'd1 << 3'(r + 3'd1)) : (5'd1 << 3'(3'd7 - r));
        CH_GREATER:    g = (r < 3'd4) ? (5'd1 << 3'(3'd3 - r)) : (5'd1 << 3'(r - 3'd3));
        CH_SPACE:      g = 5'h00;
        default:       g = DOT_ROW;
      endcase
    end
    return g;
  endfunction

endpackage

FILE: sv/wtgr_if.sv
// Stream interfaces of the glyph renderer: character input and row mask output.
// Standalone; valid/ready transfer on each channel.
interface wtgr_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       start_text;
  modport source (output valid, char_code, start_text, input ready);
  modport sink   (input valid, char_code, start_text, output ready);
endinterface

interface wtgr_row_if;
  logic        valid;
  logic        ready;
  logic [9:0]  pixel_row;
  logic [9:0]  run_start_x;
  logic [19:0] pixel_mask;
  logic [15:0] pixel_color;
  logic        last_row;
  modport source (output valid, pixel_row, run_start_x, pixel_mask, pixel_color, last_row,
                  input ready);
  modport sink   (input valid, pixel_row, run_start_x, pixel_mask, pixel_color, last_row,
                  output ready);
endinterface

FILE: sv/wtgr_cfg.sv
// APB-style register file of the glyph renderer.
// Depends on wtgr_pkg (cfg_t, reg_idx_t).
module wtgr_cfg import wtgr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x        <= 10'd24;
      cfg.origin_y        <= 10'd0;
      cfg.glyph_scale     <= 3'd2;
      cfg.line_char_limit <= 7'd38;
      cfg.line_limit      <= 4'd1;
      cfg.frame_width     <= 11'd640;
      cfg.frame_height    <= 11'd480;
      cfg.text_color      <= 16'hFFFF;
    end else if (wr) begin
      case (idx)
        REG_ORIGIN_X:        cfg.origin_x        <= pwdata[9:0];
        REG_ORIGIN_Y:        cfg.origin_y        <= pwdata[9:0];
        REG_GLYPH_SCALE:     cfg.glyph_scale     <= pwdata[2:0];
        REG_LINE_CHAR_LIMIT: cfg.line_char_limit <= pwdata[6:0];
        REG_LINE_LIMIT:      cfg.line_limit      <= pwdata[3:0];
        REG_FRAME_WIDTH:     cfg.frame_width     <= pwdata[10:0];
        REG_FRAME_HEIGHT:    cfg.frame_height    <= pwdata[10:0];
        REG_TEXT_COLOR:      cfg.text_color      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ORIGIN_X:        prdata = {22'd0, cfg.origin_x};
      REG_ORIGIN_Y:        prdata = {22'd0, cfg.origin_y};
      REG_GLYPH_SCALE:     prdata = {29'd0, cfg.glyph_scale};
      REG_LINE_CHAR_LIMIT: prdata = {25'd0, cfg.line_char_limit};
      REG_LINE_LIMIT:      prdata = {28'd0, cfg.line_limit};
      REG_FRAME_WIDTH:     prdata = {21'd0, cfg.frame_width};
      REG_FRAME_HEIGHT:    prdata = {21'd0, cfg.frame_height};
      REG_TEXT_COLOR:      prdata = {16'd0, cfg.text_color};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

FILE: sv/wtgr_front.sv
// Front end: takes characters, tracks cursor and wrap state, and queues one
// entry per drawn character with its placement. Depends on wtgr_pkg, wtgr_if.
module wtgr_front import wtgr_pkg::*; #(
  parameter int MAX_SCALE = DEF_MAX_SCALE
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  wtgr_char_if.sink    char_in,
  input  logic         q_full,
  output logic         q_push,
  output entry_t       q_data
);

  logic [6:0] column_count, column_count_next;
  logic [3:0] line_count, line_count_next;
  logic       skip_spaces, skip_spaces_next;
  logic       absorb_newline, absorb_newline_next;

  logic [6:0]         col_e;
  logic [3:0]         line_e;
  logic               skip_e, absorb_e;
  logic [7:0]         c;
  logic [6:0]         limit;
  logic               draw, accept;
  logic [SCALE_W-1:0] s;
  logic [5:0]         xstep;
  logic [6:0]         ystep;
  logic [X_W-1:0]     x;
  logic [10:0]        fw, room;

  function automatic logic [SCALE_W-1:0] clamp_scale(input logic [2:0] raw);
    logic [SCALE_W-1:0] v;
    v = SCALE_W'(raw);
    if (raw == 3'd0) v = SCALE_W'(1);
    else if (v > SCALE_W'(MAX_SCALE)) v = SCALE_W'(MAX_SCALE);
    return v;
  endfunction

  assign char_in.ready = !q_full;
  assign accept        = char_in.valid && char_in.ready;
  assign q_push        = accept && draw;

  always_comb begin
    c        = char_in.char_code;
    col_e    = char_in.start_text ? 7'd0 : column_count;
    line_e   = char_in.start_text ? 4'd0 : line_count;
    skip_e   = char_in.start_text ? 1'b0 : skip_spaces;
    absorb_e = char_in.start_text ? 1'b0 : absorb_newline;
    limit    = (cfg.line_char_limit == 7'd0) ? 7'd1 : cfg.line_char_limit;

    column_count_next   = col_e;
    line_count_next     = line_e;
    skip_spaces_next    = skip_e;
    absorb_newline_next = absorb_e;
    draw                = 1'b0;

    // past the line limit a character is swallowed with no state change
    if (line_e < cfg.line_limit) begin
      absorb_newline_next = 1'b0;
      if (!(absorb_e && c == CH_NEWLINE) && !(skip_e && c == CH_SPACE)) begin
        skip_spaces_next = 1'b0;
        if (c == CH_NEWLINE) begin
          line_count_next   = line_e + 4'd1;
          column_count_next = 7'd0;
          skip_spaces_next  = 1'b1;
        end else begin
          draw = 1'b1;
          if (({1'b0, col_e} + 8'd1) >= {1'b0, limit}) begin
            column_count_next   = 7'd0;
            line_count_next     = line_e + 4'd1;
            absorb_newline_next = 1'b1;
            skip_spaces_next    = 1'b1;
          end else begin
            column_count_next = col_e + 7'd1;
          end
        end
      end
    end
  end

  // placement of the character and its column clip, fixed for all its rows
  always_comb begin
    s     = clamp_scale(cfg.glyph_scale);
    xstep = 6'(CHAR_PITCH * s);
    ystep = 7'(LINE_PITCH * s);
    x     = X_W'(cfg.origin_x) + X_W'(col_e * xstep);
    fw    = (cfg.frame_width > FRAME_MAX) ? FRAME_MAX : cfg.frame_width;
    room  = fw - x[10:0];

    q_data.code        = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_FOLD : c;
    q_data.run_start_x = (x > X_W'(COORD_MAX)) ? COORD_MAX : x[9:0];
    q_data.ybase       = Y_W'(cfg.origin_y) + Y_W'(line_e * ystep);
    q_data.scale       = s;
    if (x >= X_W'(fw)) begin
      q_data.col_mask = '0;
    end else if (room < 11'(MASK_W)) begin
      q_data.col_mask = ~({MASK_W{1'b1}} << room[4:0]);
    end else begin
      q_data.col_mask = {MASK_W{1'b1}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= 7'd0;
      line_count     <= 4'd0;
      skip_spaces    <= 1'b0;
      absorb_newline <= 1'b0;
    end else if (accept) begin
      column_count   <= column_count_next;
      line_count     <= line_count_next;
      skip_spaces    <= skip_spaces_next;
      absorb_newline <= absorb_newline_next;
    end
  end

endmodule

FILE: sv/wtgr_queue.sv
// Short queue of drawn characters between front and back end.
// Depends on wtgr_pkg (entry_t).
module wtgr_queue import wtgr_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wdata,
  output logic   full,
  input  logic   pop,
  output entry_t rdata,
  output logic   empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [AW-1:0]   wptr, rptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      if (pop)  rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

FILE: sv/wtgr_back.sv
// Back end: walks the rows of each queued character, builds the scaled and
// clipped row mask, and holds it in the output register. Depends on wtgr_pkg, wtgr_if.
module wtgr_back import wtgr_pkg::*; #(
  parameter int MAX_SCALE = DEF_MAX_SCALE
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_empty,
  input  entry_t     q_head,
  output logic       q_pop,
  wtgr_row_if.source row_out
);

  localparam int GW = MASK_W + GLYPH_COLS * MAX_SCALE;

  entry_t             cur;
  logic               busy;
  logic [SCALE_W-1:0] sub;
  logic [2:0]         grow;
  logic [Y_W-1:0]     y;

  logic               out_valid;
  logic [9:0]         out_row;
  logic [9:0]         out_x;
  logic [MASK_W-1:0]  out_mask;
  logic [15:0]        out_color;
  logic               out_last;

  logic               adv, last;
  logic [4:0]         g;
  logic [GW-1:0]      run, wide;
  logic [MASK_W-1:0]  mask;
  logic [10:0]        fh;

  assign adv   = busy && (!out_valid || row_out.ready);
  assign last  = (grow == 3'(GLYPH_ROWS - 1)) && (sub == SCALE_W'(cur.scale - 1'b1));
  assign q_pop = !q_empty && (!busy || (adv && last));

  always_comb begin
    g    = glyph_row(cur.code, grow);
    run  = ~({GW{1'b1}} << cur.scale);
    wide = '0;
    for (int col = 0; col < GLYPH_COLS; col++) begin
      if (g[GLYPH_COLS - 1 - col]) wide = wide | (run << 6'(col * cur.scale));
    end
    fh   = (cfg.frame_height > FRAME_MAX) ? FRAME_MAX : cfg.frame_height;
    mask = (y >= Y_W'(fh)) ? '0 : (wide[MASK_W-1:0] & cur.col_mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
        out_row   <= (y > Y_W'(COORD_MAX)) ? COORD_MAX : y[9:0];
        out_x     <= cur.run_start_x;
        out_mask  <= mask;
        out_color <= cfg.text_color;
        out_last  <= last;
        y         <= y + Y_W'(1);
        if (sub == SCALE_W'(cur.scale - 1'b1)) begin
          sub  <= '0;
          grow <= grow + 3'd1;
        end else begin
          sub <= sub + SCALE_W'(1);
        end
        if (last && q_empty) busy <= 1'b0;
      end else if (row_out.ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        cur  <= q_head;
        busy <= 1'b1;
        sub  <= '0;
        grow <= 3'd0;
        y    <= q_head.ybase;
      end
    end
  end

  assign row_out.valid       = out_valid;
  assign row_out.pixel_row   = out_row;
  assign row_out.run_start_x = out_x;
  assign row_out.pixel_mask  = out_mask;
  assign row_out.pixel_color = out_color;
  assign row_out.last_row    = out_last;

endmodule

FILE: sv/wrapped_text_glyph_renderer_unit.sv
// Glyph renderer top level: turns a stream of text characters into scaled 5x7
// glyph row masks for a framebuffer, with line wrapping and clipping.
// Depends on wtgr_pkg, wtgr_if, wtgr_cfg, wtgr_front, wtgr_queue, wtgr_back.
//
// char_in carries one character per transfer (char_code, start_text).
// row_out carries one row mask per transfer; a drawn character gives
// 7*scale masks, the last flagged by last_row. Newlines, dropped spaces and
// characters past the line limit give none.
// The APB port sets placement, scale, limits, frame size and colour; write it
// only while no character is in flight.
// Throughput: one row mask per cycle while row_out is ready, set by the back
// end's row walk. The front end takes a character every cycle until its queue
// of drawn characters is full.
// When the back end is idle, the first mask of a character passes the queue,
// the back end's character register and the output register before it shows.
// Reset clears the cursor, wrap state, queue and output register, and sets
// the registers to their defaults. When row_out stalls, the mask is held,
// the back end pauses and the queue fills, after which char_in.ready drops.
module wrapped_text_glyph_renderer_unit import wtgr_pkg::*; #(
  parameter int MAX_SCALE   = DEF_MAX_SCALE,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  wtgr_char_if.sink   char_in,
  wtgr_row_if.source  row_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t   cfg;
  entry_t q_wdata, q_rdata;
  logic   q_push, q_pop, q_full, q_empty;

  wtgr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wtgr_front #(.MAX_SCALE(MAX_SCALE)) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .char_in (char_in),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  wtgr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  wtgr_back #(.MAX_SCALE(MAX_SCALE)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_head  (q_rdata),
    .q_pop   (q_pop),
    .row_out (row_out)
  );

endmodule

FILE: sv/wtgr_checker.sv
// Port-level checks of the glyph renderer output stream, bound to the top level.
// Depends on wrapped_text_glyph_renderer_unit_assert.svh.
`include "wrapped_text_glyph_renderer_unit_assert.svh"

module wtgr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [9:0]  pixel_row,
  input logic [9:0]  run_start_x,
  input logic [19:0] pixel_mask,
  input logic [15:0] pixel_color,
  input logic        last_row
);

  // a stalled mask stays put
  `WTGR_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(pixel_row) && $stable(run_start_x) && $stable(pixel_mask) && $stable(pixel_color) && $stable(last_row))

  // rows of one character follow without gaps, one framebuffer row apart
  `WTGR_ASSERT_NEXT(a_row_walk, clk, rst, out_valid && out_ready && !last_row, out_valid && $stable(run_start_x) && (pixel_row == $past(pixel_row) + 10'd1 || pixel_row == 10'd1023))

  // a saturated column leaves at most the first pixel inside the frame
  `WTGR_ASSERT_NOW(a_x_clip, clk, rst, out_valid && run_start_x == 10'd1023, pixel_mask[19:1] == 19'd0)

endmodule

bind wrapped_text_glyph_renderer_unit wtgr_checker u_wtgr_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (row_out.valid),
  .out_ready   (row_out.ready),
  .pixel_row   (row_out.pixel_row),
  .run_start_x (row_out.run_start_x),
  .pixel_mask  (row_out.pixel_mask),
  .pixel_color (row_out.pixel_color),
  .last_row    (row_out.last_row)
);
